// File: rtl/core/u8cp_pkg.sv
// u8cp_pkg: types, constants and the code point to CP437 lookup shared by
// the UTF-8 to CP437 transcoder. No dependencies.
`timescale 1ns / 1ps

package u8cp_pkg;

    localparam logic [7:0]  CH_QMARK    = 8'h3F;
    localparam logic [7:0]  CH_NUL      = 8'h00;
    localparam logic [20:0] CP_MIN_3B   = 21'h000800;
    localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [20:0] CP_MIN_4B   = 21'h010000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;

    // pending multi-byte sequence
    typedef struct packed {
        logic [1:0]  need;
        logic [1:0]  coll;
        logic [20:0] acc;
    } seq_t;

    // what one source byte asks for: up to three '?' plus an optional final
    // character, or a terminator
    typedef struct packed {
        seq_t       seq_next;
        logic [2:0] attempts;
        logic       has_char;
        logic [7:0] last_char;
        logic       term;
    } dec_t;

    function automatic logic [7:0] to_cp437(input logic [20:0] cp);
        logic [7:0] ch;
        if (cp < 21'h80)
        begin
            ch = cp[7:0];
        end
        else
        begin
            case (cp)
                21'h00A0: ch = 8'h20;
                21'h00AB: ch = 8'hAE;
                21'h00B0: ch = 8'hF8;
                21'h00B2: ch = 8'hFD;
                21'h00B3: ch = 8'h33;
                21'h00B5: ch = 8'hE6;
                21'h00BB: ch = 8'hAF;
                21'h00C4: ch = 8'h8E;
                21'h00C7: ch = 8'h80;
                21'h00C9: ch = 8'h90;
                21'h00D6: ch = 8'h99;
                21'h00DC: ch = 8'h9A;
                21'h00DF: ch = 8'hE1;
                21'h00E0: ch = 8'h85;
                21'h00E2: ch = 8'h83;
                21'h00E4: ch = 8'h84;
                21'h00E7: ch = 8'h87;
                21'h00E8: ch = 8'h8A;
                21'h00E9: ch = 8'h82;
                21'h00EA: ch = 8'h88;
                21'h00EB: ch = 8'h89;
                21'h00EE: ch = 8'h8C;
                21'h00EF: ch = 8'h8B;
                21'h00F4: ch = 8'h93;
                21'h00F6: ch = 8'h94;
                21'h00F9: ch = 8'h97;
                21'h00FB: ch = 8'h96;
                21'h00FC: ch = 8'h81;
                21'h03A9: ch = 8'hEA;
                21'h2019: ch = 8'h27;
                default:  ch = CH_QMARK;
            endcase
        end
        return ch;
    endfunction

endpackage

// File: rtl/core/u8cp_decoder.sv
// u8cp_decoder: combinational UTF-8 byte decoder. Given one source byte and
// the pending sequence, gives the next sequence state and the results asked
// for. Depends on u8cp_pkg.
`timescale 1ns / 1ps

module u8cp_decoder
(
    input  logic [7:0]     in_byte,
    input  u8cp_pkg::seq_t seq,
    output u8cp_pkg::dec_t dec
);

    logic        pending;
    logic        cont;
    logic [20:0] acc_n;
    logic [1:0]  coll_n;
    logic        bad;
    logic [1:0]  nq;

    assign pending = (seq.need != 2'd0);
    assign cont    = (in_byte[7:6] == 2'b10);
    assign acc_n   = {seq.acc[14:0], in_byte[5:0]};
    assign coll_n  = seq.coll + 2'd1;

    always_comb
    begin
        bad = 1'b0;
        if (seq.need == 2'd2)
        begin
            bad = (acc_n < u8cp_pkg::CP_MIN_3B)
                || ((acc_n >= u8cp_pkg::CP_SURR_LO) && (acc_n <= u8cp_pkg::CP_SURR_HI));
        end
        else if (seq.need == 2'd3)
        begin
            bad = (acc_n < u8cp_pkg::CP_MIN_4B) || (acc_n > u8cp_pkg::CP_MAX);
        end
    end

    always_comb
    begin
        dec           = '0;
        dec.seq_next  = seq;
        dec.last_char = u8cp_pkg::CH_QMARK;
        nq            = 2'd0;
        if (pending && cont)
        begin
            if (coll_n >= seq.need)
            begin
                dec.seq_next  = '0;
                dec.has_char  = 1'b1;
                dec.last_char = bad ? u8cp_pkg::CH_QMARK : u8cp_pkg::to_cp437(acc_n);
            end
            else
            begin
                dec.seq_next.acc  = acc_n;
                dec.seq_next.coll = coll_n;
            end
        end
        else
        begin
            // broken sequence: '?' for the lead and each collected continuation
            if (pending)
            begin
                nq = coll_n;
            end
            dec.seq_next = '0;
            if (in_byte == 8'h00)
            begin
                dec.term = 1'b1;
            end
            else if (in_byte < 8'h80)
            begin
                dec.has_char  = 1'b1;
                dec.last_char = in_byte;
            end
            else if ((in_byte >= 8'hC2) && (in_byte <= 8'hDF))
            begin
                dec.seq_next.need = 2'd1;
                dec.seq_next.acc  = {16'd0, in_byte[4:0]};
            end
            else if ((in_byte >= 8'hE0) && (in_byte <= 8'hEF))
            begin
                dec.seq_next.need = 2'd2;
                dec.seq_next.acc  = {17'd0, in_byte[3:0]};
            end
            else if ((in_byte >= 8'hF0) && (in_byte <= 8'hF4))
            begin
                dec.seq_next.need = 2'd3;
                dec.seq_next.acc  = {18'd0, in_byte[2:0]};
            end
            else
            begin
                dec.has_char = 1'b1;
            end
        end
        dec.attempts = {1'b0, nq} + {2'd0, dec.has_char};
    end

endmodule

// File: rtl/core/utf8_to_cp437_transcoder_unit.sv
// utf8_to_cp437_transcoder_unit: top level of the UTF-8 to CP437 transcoder.
// Depends on u8cp_pkg and u8cp_decoder.
`timescale 1ns / 1ps

// Usage
//   s_t*   : one UTF-8 byte per request; a zero byte ends the string.
//   m_t*   : result stream. tdata = {char_count[15:0], out_char[7:0]},
//            tuser = is_terminator, tlast = last result of that source byte.
//   cfg_*  : writes max_chars; always ready, write only while idle.
// A byte is held in the input register, is decoded into the result bundle
// register, and its first result is then on m_t*. A byte giving k results
// (k is 0 to 4) holds the bundle until all k are taken; bytes giving at
// most one result stream at one byte per cycle while m_tready is high. A
// byte that only starts or extends a sequence gives no result and leaves
// the bundle empty.
// Characters beyond max_chars (or the count width) are dropped; the
// terminator always appears and carries the count, which then returns to zero.
// When m_tready is low the bundle holds, the input register fills, and then
// s_tready drops. Reset empties both registers, clears any pending sequence
// and the count, and sets max_chars to 65535.

module utf8_to_cp437_transcoder_unit
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] out_char, [23:8] char_count
    output logic        m_tuser,    // [0] is_terminator
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [LW-1:0] CMAX = LW'({COUNT_WIDTH{1'b1}});

    logic [15:0]            max_chars_reg;
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    u8cp_pkg::seq_t         seq_reg;
    logic [COUNT_WIDTH-1:0] written_reg;
    logic [COUNT_WIDTH-1:0] written_next;

    logic                   bundle_valid_reg;
    logic                   bundle_valid_next;
    logic [2:0]             cnt_reg;
    logic [1:0]             idx_reg;
    logic [1:0]             idx_next;
    logic                   term_reg;
    logic [15:0]            base_reg;
    logic [7:0]             char_reg [4];
    logic [7:0]             char_next [4];

    u8cp_pkg::dec_t         dec;
    logic [LW-1:0]          written_ext;
    logic [LW-1:0]          maxc_ext;
    logic [LW-1:0]          limit;
    logic [LW-1:0]          avail;
    logic [2:0]             emitted;
    logic [2:0]             cnt_next;

    logic                   take;
    logic                   at_last;
    logic                   bundle_free;
    logic                   fire;

    u8cp_decoder u_dec
    (
        .in_byte (in_byte_reg),
        .seq     (seq_reg),
        .dec     (dec)
    );

    // capacity: characters still allowed in this string
    assign written_ext = LW'(written_reg);
    assign maxc_ext    = LW'(max_chars_reg);
    assign limit       = (maxc_ext < CMAX) ? maxc_ext : CMAX;
    assign avail       = (written_ext < limit) ? (limit - written_ext) : '0;
    assign emitted     = (avail < LW'(dec.attempts)) ? avail[2:0] : dec.attempts;
    assign cnt_next    = emitted + {2'd0, dec.term};
    assign written_next = dec.term ? '0 : (written_reg + COUNT_WIDTH'(emitted));

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            char_next[i] = ((3'(i) + 3'd1 == dec.attempts) && dec.has_char)
                         ? dec.last_char : u8cp_pkg::CH_QMARK;
        end
    end

    assign take        = m_tvalid && m_tready;
    assign at_last     = ({1'b0, idx_reg} + 3'd1 == cnt_reg);
    assign bundle_free = !bundle_valid_reg || (take && at_last);
    assign fire        = in_valid_reg && bundle_free;

    assign bundle_valid_next = fire ? (cnt_next != 3'd0) : bundle_valid_reg && !(take && at_last);
    assign idx_next          = fire ? 2'd0 : (take ? idx_reg + 2'd1 : idx_reg);

    assign s_tready  = !in_valid_reg || fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg    <= 16'hFFFF;
            in_valid_reg     <= 1'b0;
            seq_reg          <= '0;
            written_reg      <= '0;
            bundle_valid_reg <= 1'b0;
            idx_reg          <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_chars_reg <= cfg_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                seq_reg     <= dec.seq_next;
                written_reg <= written_next;
            end
            bundle_valid_reg <= bundle_valid_next;
            idx_reg          <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
        if (fire)
        begin
            cnt_reg  <= cnt_next;
            term_reg <= dec.term;
            base_reg <= written_ext[15:0];
            for (int i = 0; i < 4; i++)
            begin
                char_reg[i] <= char_next[i];
            end
        end
    end

    // terminator counts the characters before it; a character counts itself
    assign m_tvalid = bundle_valid_reg;
    assign m_tuser  = term_reg && at_last;
    assign m_tlast  = at_last;
    assign m_tdata  = {base_reg + 16'(idx_reg) + {15'd0, !m_tuser},
                       m_tuser ? u8cp_pkg::CH_NUL : char_reg[idx_reg]};

    a_idx_in_bundle : assert property (@(posedge clk) disable iff (!rst_n)
        bundle_valid_reg |-> ({1'b0, idx_reg} < cnt_reg) && (cnt_reg <= 3'd4))
        else $error("result index beyond bundle");

    a_term_closes_run : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("terminator not last of run");

    a_count_cleared : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && dec.term) |=> (written_reg == '0) && (seq_reg.need == 2'd0))
        else $error("count or sequence not cleared after terminator");

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for utf8_to_cp437_transcoder_unit. Feeds UTF-8 bytes
// (a directed table, then random strings under several capacity limits) and checks
// every result against the table or an in-bench transcoder. Depends on u8cp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [7:0] CH_QMARK = u8cp_pkg::CH_QMARK;
    localparam logic [7:0] CH_NUL   = u8cp_pkg::CH_NUL;

    localparam int RAND_PER_PHASE = 21;
    localparam int NUM_PHASES     = 6;
    localparam int HOLD_LEN       = 80;
    localparam int DIR_ROWS       = 26;

    // one source byte; typed rows carry their single expected result
    typedef struct packed {
        logic [7:0]  b;
        logic        typed;
        logic [7:0]  ch;
        logic        term;
        logic [15:0] cnt;
    } byte_req_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        term;
        logic [15:0] cnt;
        logic        last;
    } cp437_res_t;

    // code points with a CP437 glyph of their own, beyond ASCII
    localparam logic [0:29][15:0] MAP_CP = '{
        16'h00A0, 16'h00AB, 16'h00B0, 16'h00B2, 16'h00B3, 16'h00B5, 16'h00BB, 16'h00C4,
        16'h00C7, 16'h00C9, 16'h00D6, 16'h00DC, 16'h00DF, 16'h00E0, 16'h00E2, 16'h00E4,
        16'h00E7, 16'h00E8, 16'h00E9, 16'h00EA, 16'h00EB, 16'h00EE, 16'h00EF, 16'h00F4,
        16'h00F6, 16'h00F9, 16'h00FB, 16'h00FC, 16'h03A9, 16'h2019};
    localparam logic [0:29][7:0] MAP_CH = '{
        8'h20, 8'hAE, 8'hF8, 8'hFD, 8'h33, 8'hE6, 8'hAF, 8'h8E,
        8'h80, 8'h90, 8'h99, 8'h9A, 8'hE1, 8'h85, 8'h83, 8'h84,
        8'h87, 8'h8A, 8'h82, 8'h88, 8'h89, 8'h8C, 8'h8B, 8'h93,
        8'h94, 8'h97, 8'h96, 8'h81, 8'hEA, 8'h27};

    localparam byte_req_t [0:DIR_ROWS-1] DIR_TAB = '{
        '{8'h00, 1'b1, CH_NUL,   1'b1, 16'd0},   // terminator straight after reset
        '{8'h41, 1'b1, 8'h41,    1'b0, 16'd1},
        '{8'h80, 1'b1, CH_QMARK, 1'b0, 16'd2},   // stray continuation
        '{8'hFF, 1'b1, CH_QMARK, 1'b0, 16'd3},
        '{8'hC1, 1'b1, CH_QMARK, 1'b0, 16'd4},   // overlong-only lead
        '{8'hC2, 1'b0, 8'h00,    1'b0, 16'd0},   // U+00A0
        '{8'hA0, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'hE2, 1'b0, 8'h00,    1'b0, 16'd0},   // U+2019
        '{8'h80, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'h99, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'hE0, 1'b0, 8'h00,    1'b0, 16'd0},   // overlong three-byte
        '{8'h80, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'h80, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'hED, 1'b0, 8'h00,    1'b0, 16'd0},   // surrogate
        '{8'hA0, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'h80, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'hF4, 1'b0, 8'h00,    1'b0, 16'd0},   // above U+10FFFF
        '{8'h90, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'h80, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'h80, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'hF0, 1'b0, 8'h00,    1'b0, 16'd0},   // broken after two continuations
        '{8'h90, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'h80, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'h42, 1'b0, 8'h00,    1'b0, 16'd0},
        '{8'hC3, 1'b0, 8'h00,    1'b0, 16'd0},   // broken by the terminator
        '{8'h00, 1'b0, 8'h00,    1'b0, 16'd0}};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;             // [7:0] out_char, [23:8] char_count
    logic        m_tuser;             // [0] is_terminator
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    // predictor state
    logic [15:0] char_cap = 16'hFFFF;
    logic [1:0]  seq_need = 2'd0;
    logic [1:0]  seq_got = 2'd0;
    logic [20:0] seq_acc = 21'd0;
    logic [15:0] chars_written = 16'd0;
    cp437_res_t  burst [0:3];
    int          burst_n;

    byte_req_t   utf8_q [$];
    cp437_res_t  char_q [$];
    byte_req_t   in_flight;
    cp437_res_t  want;
    cp437_res_t  got;
    int          queued_total = 0;
    int          accepted_total = 0;
    int          mismatches = 0;
    bit          calm = 1'b0;
    bit          hold_off_req = 1'b0;
    int          held_cycles = 0;

    utf8_to_cp437_transcoder_unit #(.COUNT_WIDTH(16)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        #2000000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic [7:0] map_cp(input logic [20:0] cp);
        logic [7:0] ch;
        ch = CH_QMARK;
        if (cp < 21'h80)
        begin
            ch = cp[7:0];
        end
        else
        begin
            for (int i = 0; i < 30; i++)
                if (cp == {5'd0, MAP_CP[i]})
                    ch = MAP_CH[i];
        end
        return ch;
    endfunction

    function automatic void clear_seq();
        seq_need = 2'd0;
        seq_got  = 2'd0;
        seq_acc  = 21'd0;
    endfunction

    // characters past the cap are dropped silently
    function automatic void put_char(input logic [7:0] ch);
        if (chars_written < char_cap && chars_written != 16'hFFFF && burst_n < 4)
        begin
            chars_written = chars_written + 16'd1;
            burst[burst_n] = '{ch, 1'b0, chars_written, 1'b0};
            burst_n++;
        end
    endfunction

    // results caused by one accepted byte, left in burst[0:burst_n-1]
    function automatic void transcode_byte(input logic [7:0] b);
        logic [20:0] cp;
        logic        bad;
        logic        done;
        burst_n = 0;
        done = 1'b0;
        if (seq_need != 2'd0)
        begin
            if (b[7:6] == 2'b10)
            begin
                seq_acc = {seq_acc[14:0], b[5:0]};
                seq_got = seq_got + 2'd1;
                if (seq_got >= seq_need)
                begin
                    cp = seq_acc;
                    bad = 1'b0;
                    if (seq_need == 2'd2)
                        bad = cp < 21'h800 || (cp >= 21'hD800 && cp <= 21'hDFFF);
                    else if (seq_need == 2'd3)
                        bad = cp < 21'h10000 || cp > 21'h10FFFF;
                    put_char(bad ? CH_QMARK : map_cp(cp));
                    clear_seq();
                end
                done = 1'b1;
            end
            else
            begin
                // broken off: '?' for the lead and per collected continuation
                put_char(CH_QMARK);
                for (int i = 0; i < seq_got; i++)
                    put_char(CH_QMARK);
                clear_seq();
            end
        end
        if (!done)
        begin
            if (b == 8'h00)
            begin
                burst[burst_n] = '{CH_NUL, 1'b1, chars_written, 1'b0};
                burst_n++;
                chars_written = 16'd0;
                clear_seq();
            end
            else if (b < 8'h80)
            begin
                put_char(b);
            end
            else if (b >= 8'hC2 && b <= 8'hDF)
            begin
                seq_need = 2'd1;
                seq_acc = {16'd0, b[4:0]};
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                seq_need = 2'd2;
                seq_acc = {17'd0, b[3:0]};
            end
            else if (b >= 8'hF0 && b <= 8'hF4)
            begin
                seq_need = 2'd3;
                seq_acc = {18'd0, b[2:0]};
            end
            else
            begin
                put_char(CH_QMARK);
            end
        end
        if (burst_n > 0)
            burst[burst_n - 1].last = 1'b1;
    endfunction

    // sender, prediction at acceptance, result check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                transcode_byte(in_flight.b);
                if (in_flight.typed)
                begin
                    char_q.push_back('{in_flight.ch, in_flight.term, in_flight.cnt, 1'b1});
                end
                else
                begin
                    for (int i = 0; i < burst_n; i++)
                        char_q.push_back(burst[i]);
                end
                accepted_total++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (utf8_q.size() != 0 && (calm || $urandom_range(0, 99) >= 9))
                begin
                    in_flight = utf8_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= in_flight.b;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[7:0], m_tuser, m_tdata[23:8], m_tlast};
                if (char_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: char %h term %b count %0d last %b",
                                 got.ch, got.term, got.cnt, got.last);
                end
                else
                begin
                    want = char_q.pop_front();
                    if (got.ch != want.ch || got.term != want.term ||
                        got.cnt != want.cnt || got.last != want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp char %h term %b count %0d last %b, got %h %b %0d %b",
                                     want.ch, want.term, want.cnt, want.last,
                                     got.ch, got.term, got.cnt, got.last);
                    end
                end
            end
        end
    end

    // receiver; one long hold-off so the input side backs up
    always @(posedge clk)
    begin
        if (hold_off_req && held_cycles < HOLD_LEN)
        begin
            m_tready <= 1'b0;
            held_cycles <= held_cycles + 1;
        end
        else
        begin
            m_tready <= calm || ($urandom_range(0, 99) >= 9);
        end
    end

    task automatic push_byte(input logic [7:0] b);
        utf8_q.push_back('{b, 1'b0, 8'h00, 1'b0, 16'd0});
        queued_total++;
    endtask

    task automatic push_cont();
        push_byte(8'h80 | 8'($urandom_range(0, 63)));
    endtask

    task automatic push_cp(input logic [20:0] cp);
        if (cp < 21'h80)
        begin
            push_byte(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            push_byte({3'b110, cp[10:6]});
            push_byte({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            push_byte({4'b1110, cp[15:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end
        else
        begin
            push_byte({5'b11110, cp[20:18]});
            push_byte({2'b10, cp[17:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
        end
    endtask

    // one random unit of text: mostly well-formed, some broken or junk
    task automatic push_text_unit();
        int         pick;
        int         need;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 28)
        begin
            push_byte(8'($urandom_range(1, 127)));
        end
        else if (pick < 40)
        begin
            push_cp({5'd0, MAP_CP[$urandom_range(0, 29)]});
        end
        else if (pick < 55)
        begin
            case ($urandom_range(0, 2))
                0:       push_cp(21'($urandom_range(21'h80, 21'h7FF)));
                1:       push_cp(21'($urandom_range(21'h800, 21'hFFFF)));
                default: push_cp(21'($urandom_range(21'h10000, 21'h10FFFF)));
            endcase
        end
        else if (pick < 63)
        begin
            push_byte(8'h00);
        end
        else if (pick < 70)
        begin
            if ($urandom_range(0, 1) == 0)
                push_byte(8'($urandom_range(8'h80, 8'hC1)));
            else
                push_byte(8'($urandom_range(8'hF5, 8'hFF)));
        end
        else if (pick < 80)
        begin
            // lead, too few continuations, then any non-continuation byte
            need = $urandom_range(1, 3);
            case (need)
                1:       push_byte(8'($urandom_range(8'hC2, 8'hDF)));
                2:       push_byte(8'($urandom_range(8'hE0, 8'hEF)));
                default: push_byte(8'($urandom_range(8'hF0, 8'hF4)));
            endcase
            repeat ($urandom_range(0, need - 1))
                push_cont();
            b = 8'($urandom_range(0, 255));
            if (b[7:6] == 2'b10)
                b[6] = 1'b1;
            push_byte(b);
        end
        else if (pick < 88)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    push_byte(8'hE0);
                    push_byte(8'($urandom_range(8'h80, 8'h9F)));
                    push_cont();
                end
                1:
                begin
                    push_byte(8'hED);
                    push_byte(8'($urandom_range(8'hA0, 8'hBF)));
                    push_cont();
                end
                2:
                begin
                    push_byte(8'hF4);
                    push_byte(8'($urandom_range(8'h90, 8'hBF)));
                    push_cont();
                    push_cont();
                end
                default:
                begin
                    push_byte(8'hF0);
                    push_byte(8'($urandom_range(8'h80, 8'h8F)));
                    push_cont();
                    push_cont();
                end
            endcase
        end
        else
        begin
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // all requests taken, all results seen, pipeline given time to empty
    task automatic settle();
        while (accepted_total != queued_total || char_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cap(input logic [15:0] val);
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        char_cap = val;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int          start;
        logic [15:0] cap;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            utf8_q.push_back(DIR_TAB[i]);
            queued_total++;
        end
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            settle();
            case (p)
                0:       cap = 16'd0;
                1:       cap = 16'd1;
                2:       cap = 16'd3;
                3:       cap = 16'hFFFF;
                default: cap = 16'($urandom_range(2, 12));
            endcase
            write_cap(cap);
            calm = (p == 2);
            if (p == 3)
                hold_off_req = 1'b1;
            start = queued_total;
            while (queued_total - start < RAND_PER_PHASE)
                push_text_unit();
        end
        settle();
        if (mismatches == 0 && char_q.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
